// File: hdl/sha1_pkg.sv
package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	// front to back: one 32-bit block word, or a block-done / digest command
	typedef enum logic [1:0] {
		CMD_WORD   = 2'd0,
		CMD_BLOCK  = 2'd1,
		CMD_DIGEST = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] data;
	} q_word_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

// File: hdl/sha1_message_digest_core.sv
// channel | dir | payload                 | handshake
// in      | in  | data_byte, present, eom  | in_valid / in_stall
// out     | out | digest word, index, last | out_valid / out_stall
// One byte per cycle into the packer while in_stall is low; each full block then
// holds the compression unit for its 80 rounds, load and chain add. Only
// QueueDepth words fit in the queue meanwhile; the packer takes bytes until it backs up.
// End of message adds padding words, one or two blocks and five digest
// words. Async reset loads the initial chain.
// Either side may stall; the word queue between packer and rounds decouples them.
module sha1_message_digest_core #(
	parameter int QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha1_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output sha1_pkg::out_word_t out_word
);

	logic              fq_valid, fq_stall, qb_valid, qb_stall;
	sha1_pkg::q_word_t fq_word, qb_word;

	sha1_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.q_valid(fq_valid), .q_stall(fq_stall), .q_word(fq_word)
	);

	sha1_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_stall(fq_stall), .wr_word(fq_word),
		.rd_valid(qb_valid), .rd_stall(qb_stall), .rd_word(qb_word)
	);

	sha1_back u_back (
		.clk, .arst_n,
		.q_valid(qb_valid), .q_stall(qb_stall), .q_word(qb_word),
		.out_valid, .out_stall, .out_word
	);

endmodule

// File: hdl/sha1_front.sv
// Packs bytes into words, generates padding and length words and block and digest commands.
module sha1_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sha1_pkg::in_word_t in_word,
	output logic               q_valid,
	input  logic               q_stall,
	output sha1_pkg::q_word_t  q_word
);

	typedef enum logic [2:0] {
		F_DATA, F_PAD, F_LEN_HI, F_LEN_LO, F_DIGEST
	} fstate_t;

	fstate_t     state_q;
	logic [60:0] count_q;
	logic [23:0] part_q;
	logic [3:0]  widx_q;
	logic        blk_pending_q;
	logic        pad80_q;

	logic        take;
	logic        out_free;
	logic        q_load;
	logic [31:0] full_word;
	logic [1:0]  bpos;

	assign out_free = !q_valid || !q_stall;
	assign bpos     = count_q[1:0];
	// a block-done command must go out before anything else
	assign in_stall = (state_q != F_DATA) || blk_pending_q || !out_free;
	assign take     = in_valid && !in_stall;

	always_comb begin
		unique case (bpos)
			2'd0:    full_word = {in_word.data_byte, 24'd0};
			2'd1:    full_word = {part_q[23:16], in_word.data_byte, 16'd0};
			2'd2:    full_word = {part_q[23:8], in_word.data_byte, 8'd0};
			default: full_word = {part_q, in_word.data_byte};
		endcase
	end

	// a word is registered for the queue this cycle if the queue side is free
	always_comb begin
		q_load = 1'b0;
		if (blk_pending_q) begin
			q_load = 1'b1;
		end else begin
			unique case (state_q)
				F_DATA:  q_load = take && in_word.byte_present && (bpos == 2'd3);
				F_PAD:   q_load = !(widx_q == 4'd14 && !pad80_q);
				default: q_load = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_DATA;
			count_q       <= '0;
			widx_q        <= '0;
			blk_pending_q <= 1'b0;
			pad80_q       <= 1'b0;
			q_valid       <= 1'b0;
		end else begin
			if (out_free)
				q_valid <= q_load;
			if (out_free) begin
				if (blk_pending_q) begin
					q_word        <= '{cmd: sha1_pkg::CMD_BLOCK, data: '0};
					blk_pending_q <= 1'b0;
				end else begin
					unique case (state_q)
						F_DATA: begin
							if (take) begin
								if (in_word.byte_present) begin
									count_q <= count_q + 61'd1;
									unique case (bpos)
										2'd0: part_q[23:16] <= in_word.data_byte;
										2'd1: part_q[15:8]  <= in_word.data_byte;
										2'd2: part_q[7:0]   <= in_word.data_byte;
										default: begin
											q_word  <= '{cmd: sha1_pkg::CMD_WORD,
												data: full_word};
											widx_q  <= widx_q + 4'd1;
											if (widx_q == 4'd15)
												blk_pending_q <= 1'b1;
										end
									endcase
								end
								if (in_word.end_of_message) begin
									state_q <= F_PAD;
									pad80_q <= 1'b1;
								end
							end
						end
						F_PAD: begin
							if (widx_q == 4'd14 && !pad80_q) begin
								state_q <= F_LEN_HI;
							end else begin
								widx_q  <= widx_q + 4'd1;
								if (widx_q == 4'd15)
									blk_pending_q <= 1'b1;
								pad80_q <= 1'b0;
								if (pad80_q) begin
									unique case (bpos)
										2'd0: q_word <= '{cmd: sha1_pkg::CMD_WORD,
											data: {sha1_pkg::PAD_BYTE, 24'd0}};
										2'd1: q_word <= '{cmd: sha1_pkg::CMD_WORD,
											data: {part_q[23:16], sha1_pkg::PAD_BYTE, 16'd0}};
										2'd2: q_word <= '{cmd: sha1_pkg::CMD_WORD,
											data: {part_q[23:8], sha1_pkg::PAD_BYTE, 8'd0}};
										default: q_word <= '{cmd: sha1_pkg::CMD_WORD,
											data: {part_q, sha1_pkg::PAD_BYTE}};
									endcase
								end else begin
									q_word <= '{cmd: sha1_pkg::CMD_WORD, data: '0};
								end
							end
						end
						F_LEN_HI: begin
							q_word  <= '{cmd: sha1_pkg::CMD_WORD, data: count_q[60:29]};
							widx_q  <= widx_q + 4'd1;
							state_q <= F_LEN_LO;
						end
						F_LEN_LO: begin
							q_word        <= '{cmd: sha1_pkg::CMD_WORD,
								data: {count_q[28:0], 3'd0}};
							widx_q        <= '0;
							blk_pending_q <= 1'b1;
							state_q       <= F_DIGEST;
						end
						default: begin
							q_word  <= '{cmd: sha1_pkg::CMD_DIGEST, data: '0};
							count_q <= '0;
							state_q <= F_DATA;
						end
					endcase
				end
			end
		end
	end

	a_pad_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_LEN_HI) |-> (widx_q == 4'd14))
		else $error("length word misplaced");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		blk_pending_q |-> !take)
		else $error("byte taken with block pending");
	a_len_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_LEN_HI && out_free) |=> (state_q == F_LEN_LO))
		else $error("length sequence broken");

endmodule

// File: hdl/sha1_queue.sv
module sha1_queue #(
	parameter int Depth = sha1_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_stall,
	input  sha1_pkg::q_word_t wr_word,
	output logic              rd_valid,
	input  logic              rd_stall,
	output sha1_pkg::q_word_t rd_word
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha1_pkg::q_word_t  mem_q [Depth];
	logic [AW-1:0]      wp_q, rp_q;
	logic [AW:0]        cnt_q;
	logic               push, pop;

	assign wr_stall = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_word  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (pop)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth))
		else $error("queue overflow");

endmodule

// File: hdl/sha1_back.sv
// Runs compression rounds and emits the digest.
module sha1_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_stall,
	input  sha1_pkg::q_word_t  q_word,
	output logic               out_valid,
	input  logic               out_stall,
	output sha1_pkg::out_word_t out_word
);

	typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_EMIT} bstate_t;

	bstate_t     state_q;
	logic [31:0] w_q [16];
	logic [3:0]  wcnt_q;
	logic [6:0]  rnd_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [2:0]  emit_q;

	logic [31:0] f, k, wt, t, wnew;

	assign q_stall = (state_q != B_LOAD) || (q_word.cmd == sha1_pkg::CMD_DIGEST
		&& out_valid && out_stall);

	always_comb begin
		wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wnew = {wnew[30:0], wnew[31]};
		wt   = (rnd_q < 7'd16) ? w_q[0] : wnew;
		priority if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = sha1_pkg::K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
	end

	always_ff @(posedge clk) begin
		if (state_q == B_LOAD && q_valid && q_word.cmd == sha1_pkg::CMD_WORD)
			w_q[wcnt_q] <= q_word.data;
		if (state_q == B_ROUND) begin
			// sliding window: rounds 0-15 rotate the block through w_q[0],
			// later rounds append the expanded word
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_LOAD;
			wcnt_q    <= '0;
			rnd_q     <= '0;
			emit_q    <= '0;
			out_valid <= 1'b0;
			h_q[0] <= sha1_pkg::H0; h_q[1] <= sha1_pkg::H1; h_q[2] <= sha1_pkg::H2;
			h_q[3] <= sha1_pkg::H3; h_q[4] <= sha1_pkg::H4;
		end else begin
			if (!out_valid || !out_stall)
				out_valid <= (state_q == B_EMIT);
			unique case (state_q)
				B_LOAD: begin
					if (q_valid && !q_stall) begin
						unique case (q_word.cmd)
							sha1_pkg::CMD_WORD: wcnt_q <= wcnt_q + 4'd1;
							sha1_pkg::CMD_BLOCK: begin
								wcnt_q  <= '0;
								rnd_q   <= '0;
								a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
								d_q <= h_q[3]; e_q <= h_q[4];
								state_q <= B_ROUND;
							end
							default: begin
								emit_q  <= '0;
								state_q <= B_EMIT;
							end
						endcase
					end
				end
				B_ROUND: begin
					e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q; a_q <= t;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79)
						state_q <= B_ADD;
				end
				B_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					state_q <= B_LOAD;
				end
				default: begin
					if (!out_valid || !out_stall) begin
						out_word  <= '{digest_word: h_q[emit_q], word_index: emit_q,
							last_word: (emit_q == 3'd4)};
						emit_q    <= emit_q + 3'd1;
						if (emit_q == 3'd4) begin
							state_q <= B_LOAD;
							h_q[0] <= sha1_pkg::H0; h_q[1] <= sha1_pkg::H1;
							h_q[2] <= sha1_pkg::H2; h_q[3] <= sha1_pkg::H3;
							h_q[4] <= sha1_pkg::H4;
						end
					end
				end
			endcase
		end
	end

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (emit_q <= 3'd4))
		else $error("digest index out of range");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_ROUND && rnd_q == 7'd79) |=> (state_q == B_ADD))
		else $error("round count slip");
	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_LOAD && q_valid && q_word.cmd == sha1_pkg::CMD_BLOCK)
		|-> (wcnt_q == 4'd0))
		else $error("block command mid-block");

endmodule
